// ----- rtl/grs_pkg.sv -----
// Shared constants, command codes and state encoding for the reaction-diffusion engine.
`timescale 1ns / 1ps
package grs_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_FRAC_BITS  = 16;

   // rates always carry 16 fraction bits
   localparam int RATE_FRAC    = 16;
   // 3x3 window held in a chain of taps, newest first
   localparam int TAPS         = 9;
   localparam int DRAIN_CYCLES = 12;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_RUN   = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      REG_DIFF_A = 3'd0,
      REG_DIFF_B = 3'd1,
      REG_FEED   = 3'd2,
      REG_KILL   = 3'd3,
      REG_EDGE   = 3'd4,
      REG_WIDTH  = 3'd5,
      REG_HEIGHT = 3'd6
   } reg_type;

   typedef enum logic [1:0] {
      EDGE_CONST = 2'd0,
      EDGE_WRAP  = 2'd1
   } edge_type;

   typedef enum logic [3:0] {
      ST_CLR_ALL = 4'd0,
      ST_IDLE    = 4'd1,
      ST_WRITE   = 4'd2,
      ST_RD      = 4'd3,
      ST_RDWAIT  = 4'd4,
      ST_CLEAR   = 4'd5,
      ST_COPY    = 4'd6,
      ST_SWEEP   = 4'd7,
      ST_DRAIN   = 4'd8,
      ST_FINISH  = 4'd9
   } state_type;

endpackage

// ----- rtl/grs_grid_mem.sv -----
// Concentration store for both grids and both banks, one write and one registered read port.
`timescale 1ns / 1ps
module grs_grid_mem #(
   parameter int AW = 13,
   parameter int CW = 18
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic signed [CW-1:0] wa,
   input  logic signed [CW-1:0] wb,
   input  logic [AW-1:0]        raddr,
   output logic signed [CW-1:0] qa,
   output logic signed [CW-1:0] qb
);
   localparam int DEPTH = 1 << AW;

   logic signed [CW-1:0] mem_a [DEPTH];
   logic signed [CW-1:0] mem_b [DEPTH];
   logic signed [CW-1:0] qa_ff;
   logic signed [CW-1:0] qb_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_a[waddr] <= wa;
         mem_b[waddr] <= wb;
      end
   end

   always_ff @(posedge clock) begin
      qa_ff <= mem_a[raddr];
      qb_ff <= mem_b[raddr];
   end

   assign qa = qa_ff;
   assign qb = qb_ff;
endmodule

// ----- rtl/grs_tap_cell.sv -----
// One window tap: holds an A/B pair and passes it to the next tap on each shift.
`timescale 1ns / 1ps
module grs_tap_cell #(
   parameter int CW = 18
) (
   input  logic                 clock,
   input  logic                 shift,
   input  logic signed [CW-1:0] a_in,
   input  logic signed [CW-1:0] b_in,
   output logic signed [CW-1:0] a_q,
   output logic signed [CW-1:0] b_q
);
   logic signed [CW-1:0] a_ff;
   logic signed [CW-1:0] b_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign a_q = a_ff;
   assign b_q = b_ff;
endmodule

// ----- rtl/grs_update.sv -----
// Six-stage pipeline computing the Gray-Scott update of one cell from its 3x3 window.
`timescale 1ns / 1ps
module grs_update #(
   parameter int FRAC_BITS = 16,
   parameter int RW        = 6,
   parameter int CLW       = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [RW-1:0]                 row,
   input  logic [CLW-1:0]                col,
   input  logic signed [FRAC_BITS+1:0]   win_a [grs_pkg::TAPS],
   input  logic signed [FRAC_BITS+1:0]   win_b [grs_pkg::TAPS],
   input  logic [17:0]                   diff_a,
   input  logic [17:0]                   diff_b,
   input  logic [15:0]                   feed,
   input  logic [15:0]                   kill,
   output logic                          out_vld,
   output logic [RW-1:0]                 out_row,
   output logic [CLW-1:0]                out_col,
   output logic signed [FRAC_BITS+1:0]   out_a,
   output logic signed [FRAC_BITS+1:0]   out_b
);
   import grs_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int CW  = F + 2;
   localparam int SW  = F + 8;
   localparam int PAW = SW + 19;
   localparam int YW  = PAW - 18;
   localparam int UW  = F + 11;
   localparam int NSH = UW + 3;
   localparam int MW  = NSH - 1;
   localparam int QW  = UW + MW;
   localparam int BW  = 2 * CW;
   localparam int TW  = F + 4;
   localparam int FW  = CW + 18;
   localparam int XW  = F + 12;
   localparam int PTW = CW + TW;

   localparam longint unsigned MVAL = ((64'd1 << NSH) + 64'd4) / 64'd5;
   localparam logic [MW-1:0] MCONST = MW'(MVAL);
   localparam logic [UW-1:0] BIAS5  = UW'(64'd5 << (F + 8));
   localparam logic signed [XW-1:0] BIAS_X = XW'(64'd1 << (F + 8));
   localparam logic signed [PAW-1:0] LAPH   = PAW'(64'd10 << RATE_FRAC);
   localparam logic signed [BW-1:0]  HALF_B = BW'(64'd1 << (F - 1));
   localparam logic signed [PTW-1:0] HALF_T = PTW'(64'd1 << (F - 1));
   localparam logic signed [FW-1:0]  HALF_R = FW'(64'd1 << (RATE_FRAC - 1));
   localparam logic signed [CW:0]    ONE_E  = (CW + 1)'(64'd1 << F);
   localparam logic signed [XW-1:0]  CMAX_X = XW'({1'b0, {(CW - 1){1'b1}}});
   localparam logic signed [XW-1:0]  CMIN_X = XW'($signed({1'b1, {(CW - 1){1'b0}}}));

   logic [6:1]     vld_ff;
   logic [RW-1:0]  row_ff [6:1];
   logic [CLW-1:0] col_ff [6:1];
   logic signed [CW-1:0] a0_ff [5:1];
   logic signed [CW-1:0] b0_ff [5:1];

   // stage 1
   logic signed [SW-1:0] sa_in, sb_in, sa_ff, sb_ff;
   // stage 2
   logic signed [PAW-1:0] pa_ff, pb_ff;
   logic signed [BW-1:0]  bb_ff;
   logic signed [FW-1:0]  pf_ff, pk_ff;
   // stage 3
   logic [UW-1:0]         ua_in, ub_in, ua_ff, ub_ff;
   logic signed [TW-1:0]  t_ff;
   logic signed [XW-1:0]  ft3_ff, kt3_ff;
   // stage 4
   logic [QW-1:0]         qa_ff, qb_ff;
   logic signed [PTW-1:0] pabb_ff;
   logic signed [XW-1:0]  ft4_ff, kt4_ff;
   // stage 5
   logic signed [XW-1:0]  da_ff, db_ff, abb_ff, ft5_ff, kt5_ff;
   // stage 6
   logic signed [XW-1:0]  va_in, vb_in;
   logic signed [CW-1:0]  oa_ff, ob_ff;
   logic signed [YW-1:0]  ya_in, yb_in;
   logic signed [17:0]    kf_e;

   always_comb begin
      sa_in = SW'(win_a[0]) + SW'(win_a[2]) + SW'(win_a[6]) + SW'(win_a[8])
            + ((SW'(win_a[1]) + SW'(win_a[3]) + SW'(win_a[5]) + SW'(win_a[7])) <<< 2)
            - SW'(win_a[4]) * SW'(20);
      sb_in = SW'(win_b[0]) + SW'(win_b[2]) + SW'(win_b[6]) + SW'(win_b[8])
            + ((SW'(win_b[1]) + SW'(win_b[3]) + SW'(win_b[5]) + SW'(win_b[7])) <<< 2)
            - SW'(win_b[4]) * SW'(20);
   end

   assign kf_e  = $signed({1'b0, 17'({1'b0, kill} + {1'b0, feed})});
   assign ya_in = YW'((pa_ff + LAPH) >>> 18);
   assign yb_in = YW'((pb_ff + LAPH) >>> 18);
   assign ua_in = UW'(ya_in) + BIAS5;
   assign ub_in = UW'(yb_in) + BIAS5;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:1], start};
      end
   end

   always_ff @(posedge clock) begin
      row_ff[1] <= row;
      col_ff[1] <= col;
      for (int i = 2; i <= 6; i++) begin
         row_ff[i] <= row_ff[i-1];
         col_ff[i] <= col_ff[i-1];
      end
      a0_ff[1] <= win_a[4];
      b0_ff[1] <= win_b[4];
      for (int i = 2; i <= 5; i++) begin
         a0_ff[i] <= a0_ff[i-1];
         b0_ff[i] <= b0_ff[i-1];
      end
      // stage 1: Laplacian sums
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      // stage 2: products
      pa_ff <= sa_ff * $signed({1'b0, diff_a});
      pb_ff <= sb_ff * $signed({1'b0, diff_b});
      bb_ff <= b0_ff[1] * b0_ff[1];
      pf_ff <= $signed({1'b0, feed}) * (ONE_E - (CW + 1)'(a0_ff[1]));
      pk_ff <= kf_e * b0_ff[1];
      // stage 3: round and bias for the divide by five
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      t_ff   <= TW'((bb_ff + HALF_B) >>> F);
      ft3_ff <= XW'((pf_ff + HALF_R) >>> RATE_FRAC);
      kt3_ff <= XW'((pk_ff + HALF_R) >>> RATE_FRAC);
      // stage 4: reciprocal multiply, a*b*b
      qa_ff   <= QW'(ua_ff) * QW'(MCONST);
      qb_ff   <= QW'(ub_ff) * QW'(MCONST);
      pabb_ff <= a0_ff[3] * t_ff;
      ft4_ff  <= ft3_ff;
      kt4_ff  <= kt3_ff;
      // stage 5
      da_ff  <= $signed(XW'(qa_ff >> NSH)) - BIAS_X;
      db_ff  <= $signed(XW'(qb_ff >> NSH)) - BIAS_X;
      abb_ff <= XW'((pabb_ff + HALF_T) >>> F);
      ft5_ff <= ft4_ff;
      kt5_ff <= kt4_ff;
      // stage 6: saturate
      if (va_in > CMAX_X) begin
         oa_ff <= CMAX_X[CW-1:0];
      end else if (va_in < CMIN_X) begin
         oa_ff <= CMIN_X[CW-1:0];
      end else begin
         oa_ff <= va_in[CW-1:0];
      end
      if (vb_in > CMAX_X) begin
         ob_ff <= CMAX_X[CW-1:0];
      end else if (vb_in < CMIN_X) begin
         ob_ff <= CMIN_X[CW-1:0];
      end else begin
         ob_ff <= vb_in[CW-1:0];
      end
   end

   assign va_in = XW'(a0_ff[5]) + da_ff - abb_ff + ft5_ff;
   assign vb_in = XW'(b0_ff[5]) + db_ff + abb_ff - kt5_ff;

   assign out_vld = vld_ff[6];
   assign out_row = row_ff[6];
   assign out_col = col_ff[6];
   assign out_a   = oa_ff;
   assign out_b   = ob_ff;
endmodule

// ----- rtl/gray_scott_reaction_diffusion.sv -----
// Top level: command sequencer, border mapping, window tap chain, store and result register.
// Run, for each generation (CELLS = MAX_WIDTH*MAX_HEIGHT): a bank copy at one cell a cycle, then three
// store reads per window column on the single read port, then a drain of the update pipeline.
// One command is worked at a time; the next is taken as soon as the sequencer returns to idle.
// After reset a clearing pass over both banks (all 2*CELLS words) holds req_tready low.
`timescale 1ns / 1ps
module gray_scott_reaction_diffusion #(
   parameter int MAX_WIDTH  = grs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = grs_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = grs_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // row[5:0], col[11:6], a_in[29:12], b_in[47:30], extra_generations[55:48]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // a_out[17:0], b_out[35:18], zero[39:36]
   output logic [1:0]  rsp_tuser,   // done_kind[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_data
);
   import grs_pkg::*;

   localparam int CW  = FRAC_BITS + 2;
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int CIW = RW + CLW;
   localparam int AW  = CIW + 1;
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int PR  = RW + 2;
   localparam int PC  = CLW + 2;
   localparam int EW  = ((CW > 18) ? CW : 18) + 1;

   localparam logic signed [CW-1:0] ONE_VAL = CW'(64'd1 << FRAC_BITS);
   localparam logic signed [EW-1:0] CMAX_X  = EW'({1'b0, {(CW - 1){1'b1}}});
   localparam logic signed [EW-1:0] CMIN_X  = EW'($signed({1'b1, {(CW - 1){1'b0}}}));
   localparam logic signed [EW-1:0] OMAX_X  = EW'({1'b0, {17{1'b1}}});
   localparam logic signed [EW-1:0] OMIN_X  = EW'($signed({1'b1, {17{1'b0}}}));

   // configuration
   logic [17:0] diff_a_ff, diff_b_ff;
   logic [15:0] feed_ff, kill_ff;
   logic [1:0]  edge_ff;
   logic [6:0]  width_ff, height_ff;

   // sequencer
   state_type            state_ff, state_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [RW-1:0]        r_ff, r_in;
   logic signed [PC-1:0] cc_ff, cc_in;
   logic [1:0]           k_ff, k_in;
   logic [7:0]           gen_ff, gen_in;
   logic [3:0]           drain_ff, drain_in;
   logic                 bank_ff, bank_in;
   func_type             cmd_func_ff, cmd_func_in;
   logic [5:0]           cmd_row_ff, cmd_row_in, cmd_col_ff, cmd_col_in;
   logic signed [17:0]   cmd_a_ff, cmd_a_in, cmd_b_ff, cmd_b_in;
   logic signed [17:0]   res_a_ff, res_a_in, res_b_ff, res_b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [17:0]   rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;

   // copy and fetch pipeline
   logic                 cp_vld_ff, cp_vld_in;
   logic [CIW-1:0]       cp_addr_ff, cp_addr_in;
   logic                 f_vld_ff, f_vld_in, f_const_ff, f_const_in, f_tag_ff, f_tag_in;
   logic [RW-1:0]        f_row_ff;
   logic [CLW-1:0]       f_col_ff, f_col_in;
   logic                 s_vld_ff;
   logic [RW-1:0]        s_row_ff;
   logic [CLW-1:0]       s_col_ff;

   logic [HW-1:0]        h_use;
   logic [WW-1:0]        w_use;
   logic                 cmd_inside;
   logic signed [PR-1:0] rr_s, rmap;
   logic signed [PC-1:0] cmap;
   logic                 fetch_out;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic signed [CW-1:0] mem_wa, mem_wb, q_a, q_b;
   logic signed [CW-1:0] sat_a, sat_b;
   logic signed [17:0]   rd_a, rd_b;
   logic signed [EW-1:0] ain_x, bin_x, qa_x, qb_x;

   logic signed [CW-1:0] sh_a, sh_b;
   logic signed [CW-1:0] tap_a [TAPS];
   logic signed [CW-1:0] tap_b [TAPS];

   logic                 upd_vld;
   logic [RW-1:0]        upd_row;
   logic [CLW-1:0]       upd_col;
   logic signed [CW-1:0] upd_a, upd_b;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_a_ff <= 18'd65536;
         diff_b_ff <= 18'd32768;
         feed_ff   <= 16'd3604;
         kill_ff   <= 16'd4063;
         edge_ff   <= EDGE_CONST;
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
      end else if (csr_valid) begin
         unique case (reg_type'(csr_index))
            REG_DIFF_A: diff_a_ff <= csr_data;
            REG_DIFF_B: diff_b_ff <= csr_data;
            REG_FEED:   feed_ff   <= csr_data[15:0];
            REG_KILL:   kill_ff   <= csr_data[15:0];
            REG_EDGE:   edge_ff   <= csr_data[1:0];
            REG_WIDTH:  width_ff  <= csr_data[6:0];
            REG_HEIGHT: height_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // sizes in use, zero counts as one and values above the maximum count as the maximum
   always_comb begin
      if (height_ff == 7'd0) begin
         h_use = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_use = HW'(MAX_HEIGHT);
      end else begin
         h_use = HW'(height_ff);
      end
      if (width_ff == 7'd0) begin
         w_use = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_use = WW'(MAX_WIDTH);
      end else begin
         w_use = WW'(width_ff);
      end
   end

   assign cmd_inside = (32'(cmd_row_ff) < 32'(h_use)) && (32'(cmd_col_ff) < 32'(w_use));

   // border mapping of the neighbour being fetched
   always_comb begin
      rr_s = PR'(r_ff) + PR'(k_ff) - PR'(1);
      fetch_out = (rr_s < 0) || (rr_s >= $signed(PR'(h_use)))
               || (cc_ff < 0) || (cc_ff >= $signed(PC'(w_use)));
      rmap = rr_s;
      cmap = cc_ff;
      if (edge_ff == EDGE_WRAP) begin
         if (rr_s < 0) begin
            rmap = $signed(PR'(h_use)) - PR'(1);
         end else if (rr_s >= $signed(PR'(h_use))) begin
            rmap = '0;
         end
         if (cc_ff < 0) begin
            cmap = $signed(PC'(w_use)) - PC'(1);
         end else if (cc_ff >= $signed(PC'(w_use))) begin
            cmap = '0;
         end
      end else begin
         if (rr_s < 0) begin
            rmap = '0;
         end else if (rr_s >= $signed(PR'(h_use))) begin
            rmap = $signed(PR'(h_use)) - PR'(1);
         end
         if (cc_ff < 0) begin
            cmap = '0;
         end else if (cc_ff >= $signed(PC'(w_use))) begin
            cmap = $signed(PC'(w_use)) - PC'(1);
         end
      end
   end

   // saturation of written and read values
   always_comb begin
      ain_x = EW'(cmd_a_ff);
      bin_x = EW'(cmd_b_ff);
      qa_x  = EW'(q_a);
      qb_x  = EW'(q_b);
      if (ain_x > CMAX_X) begin
         sat_a = CMAX_X[CW-1:0];
      end else if (ain_x < CMIN_X) begin
         sat_a = CMIN_X[CW-1:0];
      end else begin
         sat_a = ain_x[CW-1:0];
      end
      if (bin_x > CMAX_X) begin
         sat_b = CMAX_X[CW-1:0];
      end else if (bin_x < CMIN_X) begin
         sat_b = CMIN_X[CW-1:0];
      end else begin
         sat_b = bin_x[CW-1:0];
      end
      if (qa_x > OMAX_X) begin
         rd_a = OMAX_X[17:0];
      end else if (qa_x < OMIN_X) begin
         rd_a = OMIN_X[17:0];
      end else begin
         rd_a = qa_x[17:0];
      end
      if (qb_x > OMAX_X) begin
         rd_b = OMAX_X[17:0];
      end else if (qb_x < OMIN_X) begin
         rd_b = OMIN_X[17:0];
      end else begin
         rd_b = qb_x[17:0];
      end
   end

   // store ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wa    = ONE_VAL;
      mem_wb    = '0;
      priority if (cp_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = {~bank_ff, cp_addr_ff};
         mem_wa    = q_a;
         mem_wb    = q_b;
      end else if (upd_vld) begin
         mem_we    = 1'b1;
         mem_waddr = {~bank_ff, upd_row, upd_col};
         mem_wa    = upd_a;
         mem_wb    = upd_b;
      end else if (state_ff == ST_CLR_ALL) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = {bank_ff, cnt_ff[CIW-1:0]};
      end else if (state_ff == ST_WRITE && cmd_inside) begin
         mem_we    = 1'b1;
         mem_waddr = {bank_ff, RW'(cmd_row_ff), CLW'(cmd_col_ff)};
         mem_wa    = sat_a;
         mem_wb    = sat_b;
      end else begin
         mem_we = 1'b0;
      end

      if (state_ff == ST_COPY) begin
         mem_raddr = {bank_ff, cnt_ff[CIW-1:0]};
      end else if (state_ff == ST_SWEEP) begin
         mem_raddr = {bank_ff, RW'(rmap), CLW'(cmap)};
      end else begin
         mem_raddr = {bank_ff, RW'(cmd_row_ff), CLW'(cmd_col_ff)};
      end
   end

   grs_grid_mem #(
      .AW (AW),
      .CW (CW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wa    (mem_wa),
      .wb    (mem_wb),
      .raddr (mem_raddr),
      .qa    (q_a),
      .qb    (q_b)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      r_in        = r_ff;
      cc_in       = cc_ff;
      k_in        = k_ff;
      gen_in      = gen_ff;
      drain_in    = drain_ff;
      bank_in     = bank_ff;
      cmd_func_in = cmd_func_ff;
      cmd_row_in  = cmd_row_ff;
      cmd_col_in  = cmd_col_ff;
      cmd_a_in    = cmd_a_ff;
      cmd_b_in    = cmd_b_ff;
      res_a_in    = res_a_ff;
      res_b_in    = res_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_a_in    = rsp_a_ff;
      rsp_b_in    = rsp_b_ff;
      rsp_kind_in = rsp_kind_ff;
      cp_vld_in   = 1'b0;
      cp_addr_in  = cnt_ff[CIW-1:0];
      req_tready  = 1'b0;

      unique case (state_ff)
         ST_CLR_ALL: begin
            if (&cnt_ff) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_func_in = func_type'(req_tuser);
               cmd_row_in  = req_tdata[5:0];
               cmd_col_in  = req_tdata[11:6];
               cmd_a_in    = req_tdata[29:12];
               cmd_b_in    = req_tdata[47:30];
               gen_in      = req_tdata[55:48];
               res_a_in    = '0;
               res_b_in    = '0;
               cnt_in      = '0;
               unique case (func_type'(req_tuser))
                  FUNC_WRITE: state_in = ST_WRITE;
                  FUNC_READ:  state_in = ST_RD;
                  FUNC_RUN:   state_in = ST_COPY;
                  FUNC_CLEAR: state_in = ST_CLEAR;
               endcase
            end
         end
         ST_WRITE: state_in = ST_FINISH;
         ST_RD:    state_in = ST_RDWAIT;
         ST_RDWAIT: begin
            if (cmd_inside) begin
               res_a_in = rd_a;
               res_b_in = rd_b;
            end
            state_in = ST_FINISH;
         end
         ST_CLEAR: begin
            if (&cnt_ff[CIW-1:0]) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_COPY: begin
            cp_vld_in = 1'b1;
            if (&cnt_ff[CIW-1:0]) begin
               cnt_in   = '0;
               r_in     = '0;
               cc_in    = -PC'(1);
               k_in     = '0;
               state_in = ST_SWEEP;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_SWEEP: begin
            if (k_ff == 2'd2) begin
               k_in = '0;
               if (cc_ff == $signed(PC'(w_use))) begin
                  cc_in = -PC'(1);
                  if (r_ff == RW'(h_use - HW'(1))) begin
                     drain_in = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     r_in = r_ff + RW'(1);
                  end
               end else begin
                  cc_in = cc_ff + PC'(1);
               end
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == 4'(DRAIN_CYCLES - 1)) begin
               bank_in = ~bank_ff;
               if (gen_ff == 8'd0) begin
                  state_in = ST_FINISH;
               end else begin
                  gen_in   = gen_ff - 8'd1;
                  cnt_in   = '0;
                  state_in = ST_COPY;
               end
            end else begin
               drain_in = drain_ff + 4'd1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_a_in     = res_a_ff;
               rsp_b_in     = res_b_ff;
               rsp_kind_in  = cmd_func_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fetch tags: a window is complete after the third word of each column, from the third column of a row on
   assign f_vld_in   = (state_ff == ST_SWEEP);
   assign f_const_in = fetch_out && (edge_ff == EDGE_CONST);
   assign f_tag_in   = (k_ff == 2'd2) && (cc_ff >= 1);
   assign f_col_in   = CLW'(cc_ff - PC'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_ALL;
         cnt_ff       <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cp_vld_ff    <= 1'b0;
         f_vld_ff     <= 1'b0;
         s_vld_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         cp_vld_ff    <= cp_vld_in;
         f_vld_ff     <= f_vld_in;
         s_vld_ff     <= f_vld_ff && f_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      cc_ff       <= cc_in;
      k_ff        <= k_in;
      gen_ff      <= gen_in;
      drain_ff    <= drain_in;
      cmd_func_ff <= cmd_func_in;
      cmd_row_ff  <= cmd_row_in;
      cmd_col_ff  <= cmd_col_in;
      cmd_a_ff    <= cmd_a_in;
      cmd_b_ff    <= cmd_b_in;
      res_a_ff    <= res_a_in;
      res_b_ff    <= res_b_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_kind_ff <= rsp_kind_in;
      cp_addr_ff  <= cp_addr_in;
      f_const_ff  <= f_const_in;
      f_tag_ff    <= f_tag_in;
      f_row_ff    <= r_ff;
      f_col_ff    <= f_col_in;
      s_row_ff    <= f_row_ff;
      s_col_ff    <= f_col_ff;
   end

   // window chain, newest word at tap 0
   assign sh_a = f_const_ff ? ONE_VAL : q_a;
   assign sh_b = f_const_ff ? '0 : q_b;

   for (genvar j = 0; j < TAPS; j++) begin : g_tap
      if (j == 0) begin : g_head
         grs_tap_cell #(.CW (CW)) u_tap (
            .clock (clock),
            .shift (f_vld_ff),
            .a_in  (sh_a),
            .b_in  (sh_b),
            .a_q   (tap_a[j]),
            .b_q   (tap_b[j])
         );
      end else begin : g_body
         grs_tap_cell #(.CW (CW)) u_tap (
            .clock (clock),
            .shift (f_vld_ff),
            .a_in  (tap_a[j-1]),
            .b_in  (tap_b[j-1]),
            .a_q   (tap_a[j]),
            .b_q   (tap_b[j])
         );
      end
   end

   grs_update #(
      .FRAC_BITS (FRAC_BITS),
      .RW        (RW),
      .CLW       (CLW)
   ) u_update (
      .clock   (clock),
      .reset   (reset),
      .start   (s_vld_ff),
      .row     (s_row_ff),
      .col     (s_col_ff),
      .win_a   (tap_a),
      .win_b   (tap_b),
      .diff_a  (diff_a_ff),
      .diff_b  (diff_b_ff),
      .feed    (feed_ff),
      .kill    (kill_ff),
      .out_vld (upd_vld),
      .out_row (upd_row),
      .out_col (upd_col),
      .out_a   (upd_a),
      .out_b   (upd_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_b_ff, rsp_a_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // no store write while a new word may be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mem_we)
      else $error("store written while idle");

   // updated cells land only during a sweep or its drain
   a_upd_window: assert property (@(posedge clock) disable iff (reset)
      upd_vld |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("cell update outside a generation");

   // copy writes come in the cycle after their copy reads
   a_copy_follow: assert property (@(posedge clock) disable iff (reset)
      cp_vld_ff |-> $past(state_ff) == ST_COPY)
      else $error("copy write without copy read");

   // a result word appears only out of the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside finish");
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the reaction-diffusion engine: directed and random commands.
`timescale 1ns / 1ps
module tb_top;
   import grs_pkg::*;

   localparam int GRID_W    = DEF_MAX_WIDTH;
   localparam int GRID_H    = DEF_MAX_HEIGHT;
   localparam int CELL_CNT  = GRID_W * GRID_H;
   localparam longint ONE   = 65536;
   localparam longint C_MAX = 131071;
   localparam longint C_MIN = -131072;
   localparam int IDLE_LIMIT = 5000000;

   typedef struct {
      logic [17:0] a;
      logic [17:0] b;
      func_type    kind;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [17:0] csr_data = '0;

   gray_scott_reaction_diffusion u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // shadow copy of the engine state
   int          grid_a_sh[2][CELL_CNT];
   int          grid_b_sh[2][CELL_CNT];
   bit          bank_sh;
   logic [17:0] rate_da, rate_db;
   logic [15:0] rate_feed, rate_kill;
   logic [1:0]  border_mode;
   logic [6:0]  cols_reg, rows_reg;

   reading_type pending_q[$];
   int          mismatches = 0;
   int          words_seen = 0;
   int          cmds_sent = 0;
   int          gens_run = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_len = 0;
   bit          hold_start = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic int used_dim(logic [6:0] v, int lim);
      if (v < 1) return 1;
      return (v > lim) ? lim : int'(v);
   endfunction

   function automatic longint div_rnd(longint n, longint d);
      longint x, q;
      x = n + d / 2;
      q = x / d;
      if (x % d != 0 && x < 0) q--;
      return q;
   endfunction

   function automatic longint sat_cell(longint v);
      return (v < C_MIN) ? C_MIN : ((v > C_MAX) ? C_MAX : v);
   endfunction

   function automatic void neighbour(int bk, int r, int c, int h, int w,
                                     output longint a, output longint b);
      if (r < 0 || r >= h || c < 0 || c >= w) begin
         if (border_mode == EDGE_CONST) begin
            a = ONE;
            b = 0;
            return;
         end
         if (border_mode == EDGE_WRAP) begin
            if (r < 0) r = h - 1; else if (r >= h) r = 0;
            if (c < 0) c = w - 1; else if (c >= w) c = 0;
         end else begin
            if (r < 0) r = 0; else if (r >= h) r = h - 1;
            if (c < 0) c = 0; else if (c >= w) c = w - 1;
         end
      end
      a = grid_a_sh[bk][r * GRID_W + c];
      b = grid_b_sh[bk][r * GRID_W + c];
   endfunction

   function automatic void step_generation();
      int src, dst, h, w, wgt;
      longint sa, sb, na, nb, a0, b0, t, abb, va, vb, kf, lap_den;
      src = bank_sh;
      dst = !bank_sh;
      h = used_dim(rows_reg, GRID_H);
      w = used_dim(cols_reg, GRID_W);
      lap_den = longint'(20) << RATE_FRAC;
      kf = longint'(rate_kill) + longint'(rate_feed);
      for (int i = 0; i < CELL_CNT; i++) begin
         grid_a_sh[dst][i] = grid_a_sh[src][i];
         grid_b_sh[dst][i] = grid_b_sh[src][i];
      end
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            sa = 0;
            sb = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  wgt = (dr == 0 && dc == 0) ? -20 : ((dr == 0 || dc == 0) ? 4 : 1);
                  neighbour(src, r + dr, c + dc, h, w, na, nb);
                  sa += wgt * na;
                  sb += wgt * nb;
               end
            end
            a0 = grid_a_sh[src][r * GRID_W + c];
            b0 = grid_b_sh[src][r * GRID_W + c];
            t = div_rnd(b0 * b0, ONE);
            abb = div_rnd(a0 * t, ONE);
            va = a0 + div_rnd(sa * longint'(rate_da), lap_den) - abb
                 + div_rnd(longint'(rate_feed) * (ONE - a0), longint'(1) << RATE_FRAC);
            vb = b0 + div_rnd(sb * longint'(rate_db), lap_den) + abb
                 - div_rnd(kf * b0, longint'(1) << RATE_FRAC);
            grid_a_sh[dst][r * GRID_W + c] = int'(sat_cell(va));
            grid_b_sh[dst][r * GRID_W + c] = int'(sat_cell(vb));
         end
      end
      bank_sh = !bank_sh;
   endfunction

   function automatic void clear_shadow(int bk);
      for (int i = 0; i < CELL_CNT; i++) begin
         grid_a_sh[bk][i] = int'(ONE);
         grid_b_sh[bk][i] = 0;
      end
   endfunction

   // work out the result word of one accepted command and queue it
   function automatic void predict_command(func_type f, logic [5:0] row, logic [5:0] col,
                                           logic [17:0] a_in, logic [17:0] b_in,
                                           logic [7:0] extra);
      reading_type res;
      bit          hit;
      int          idx;
      hit = (row < used_dim(rows_reg, GRID_H)) && (col < used_dim(cols_reg, GRID_W));
      idx = row * GRID_W + col;
      res.a = '0;
      res.b = '0;
      res.kind = f;
      case (f)
         FUNC_WRITE: begin
            if (hit) begin
               grid_a_sh[bank_sh][idx] = int'(sat_cell(longint'($signed(a_in))));
               grid_b_sh[bank_sh][idx] = int'(sat_cell(longint'($signed(b_in))));
            end
         end
         FUNC_READ: begin
            if (hit) begin
               res.a = 18'(grid_a_sh[bank_sh][idx]);
               res.b = 18'(grid_b_sh[bank_sh][idx]);
            end
         end
         FUNC_RUN: begin
            for (int g = 0; g <= int'(extra); g++) step_generation();
            gens_run += int'(extra) + 1;
         end
         default: clear_shadow(bank_sh);
      endcase
      pending_q = {pending_q, res};
   endfunction

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = hold_len;
         hold_start = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: a=%h b=%h kind=%0d",
                        rsp_tdata[17:0], rsp_tdata[35:18], rsp_tuser);
         end else begin
            exp_r = pending_q.pop_front();
            if (rsp_tdata[17:0] !== exp_r.a || rsp_tdata[35:18] !== exp_r.b ||
                rsp_tuser !== exp_r.kind) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected a=%h b=%h kind=%0d, got a=%h b=%h kind=%0d",
                           exp_r.a, exp_r.b, exp_r.kind,
                           rsp_tdata[17:0], rsp_tdata[35:18], rsp_tuser);
            end
         end
      end
   end

   // watchdog on cycles with no word moving anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_cmd(func_type f, logic [5:0] row, logic [5:0] col,
                           logic [17:0] a_in, logic [17:0] b_in, logic [7:0] extra);
      // drop valid only when a gap is taken, so it is never lowered and raised in one step
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {extra, b_in, a_in, col, row};
      do @(posedge clock); while (!req_tready);
      predict_command(f, row, col, a_in, b_in, extra);
      cmds_sent++;
   endtask

   task automatic write_reg(reg_type idx, logic [17:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DIFF_A: rate_da = value;
         REG_DIFF_B: rate_db = value;
         REG_FEED:   rate_feed = value[15:0];
         REG_KILL:   rate_kill = value[15:0];
         REG_EDGE:   border_mode = value[1:0];
         REG_WIDTH:  cols_reg = value[6:0];
         REG_HEIGHT: rows_reg = value[6:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES + 4) @(posedge clock);
   endtask

   task automatic set_all_regs(logic [17:0] da, logic [17:0] db, logic [15:0] f,
                               logic [15:0] k, logic [1:0] em, logic [6:0] w, logic [6:0] h);
      wait_idle();
      write_reg(REG_DIFF_A, da);
      write_reg(REG_DIFF_B, db);
      write_reg(REG_FEED, {2'b0, f});
      write_reg(REG_KILL, {2'b0, k});
      write_reg(REG_EDGE, {16'b0, em});
      write_reg(REG_WIDTH, {11'b0, w});
      write_reg(REG_HEIGHT, {11'b0, h});
   endtask

   task automatic test_reset_grid();
      send_cmd(FUNC_READ, 0, 0, 0, 0, 0);
      send_cmd(FUNC_READ, 63, 63, 0, 0, 0);
      send_cmd(FUNC_WRITE, 5, 5, 18'h1FFFF, 18'h20000, 0);
      send_cmd(FUNC_READ, 5, 5, 0, 0, 0);
      send_cmd(FUNC_WRITE, 0, 63, 18'h20000, 18'h1FFFF, 0);
      send_cmd(FUNC_WRITE, 63, 0, 18'h3FFFF, 18'h00001, 0);
      send_cmd(FUNC_RUN, 0, 0, 0, 0, 0);
      send_cmd(FUNC_READ, 5, 5, 0, 0, 0);
      send_cmd(FUNC_READ, 4, 4, 0, 0, 0);
      send_cmd(FUNC_READ, 0, 63, 0, 0, 0);
      send_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
      send_cmd(FUNC_READ, 5, 5, 0, 0, 0);
   endtask

   task automatic test_small_wrap();
      set_all_regs(18'h3FFFF, 18'h3FFFF, 16'hFFFF, 16'hFFFF, EDGE_WRAP, 4, 4);
      send_cmd(FUNC_WRITE, 1, 2, 18'h08000, 18'h10000, 0);
      send_cmd(FUNC_WRITE, 3, 3, 18'h2AAAA, 18'h15555, 0);
      send_cmd(FUNC_WRITE, 10, 10, 18'h01234, 18'h04321, 0);
      send_cmd(FUNC_READ, 10, 10, 0, 0, 0);
      send_cmd(FUNC_RUN, 0, 0, 0, 0, 8'd4);
      send_cmd(FUNC_READ, 1, 2, 0, 0, 0);
      send_cmd(FUNC_READ, 3, 0, 0, 0, 0);
   endtask

   // width 0 counts as one column; clamp under the unnamed fourth border mode
   task automatic test_long_run();
      set_all_regs(18'h0, 18'h0, 16'h0, 16'h0, 2'd3, 7'd0, 7'd2);
      write_reg(reg_type'(3'd7), 18'h3FFFF);
      write_reg(REG_DIFF_A, 18'd30000);
      write_reg(REG_DIFF_B, 18'd15000);
      write_reg(REG_FEED, 18'd3604);
      send_cmd(FUNC_WRITE, 1, 0, 18'h0C000, 18'h06000, 0);
      send_cmd(FUNC_RUN, 0, 0, 0, 0, 8'hF8);
      send_cmd(FUNC_READ, 1, 0, 0, 0, 0);
      send_cmd(FUNC_READ, 0, 0, 0, 0, 0);
   endtask

   task automatic random_regs();
      logic [6:0] w, h;
      case ($urandom_range(9))
         0: begin w = 0; h = 127; end
         1: begin w = 64; h = 64; end
         2: begin w = 127; h = 1; end
         default: begin
            w = 7'($urandom_range(1, 8));
            h = 7'($urandom_range(1, 8));
         end
      endcase
      set_all_regs(($urandom_range(3) == 0) ? 18'h3FFFF : 18'($urandom_range(0, 131072)),
                   ($urandom_range(3) == 0) ? 18'h0 : 18'($urandom_range(0, 131072)),
                   16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                   2'($urandom_range(3)), w, h);
   endtask

   task automatic random_cmd();
      int h, w, sel;
      logic [5:0] row, col;
      logic [7:0] extra;
      h = used_dim(rows_reg, GRID_H);
      w = used_dim(cols_reg, GRID_W);
      if ($urandom_range(9) < 8) begin
         row = 6'($urandom_range(0, h - 1));
         col = 6'($urandom_range(0, w - 1));
      end else begin
         row = 6'($urandom);
         col = 6'($urandom);
      end
      extra = (h * w > 64) ? 8'd0 : 8'($urandom_range(0, 3));
      sel = $urandom_range(99);
      if (sel < 42)
         send_cmd(FUNC_WRITE, row, col, 18'($urandom), 18'($urandom), 8'($urandom));
      else if (sel < 80)
         send_cmd(FUNC_READ, row, col, 18'($urandom), 18'($urandom), 8'($urandom_range(0, 7)));
      else if (sel < 93)
         send_cmd(FUNC_RUN, row, col, 18'($urandom), 18'($urandom), extra);
      else
         send_cmd(FUNC_CLEAR, row, col, 18'($urandom), 18'($urandom), 0);
   endtask

   task automatic test_random_phase(int idle_pct, int stall);
      random_regs();
      send_idle_pct = idle_pct;
      stall_pct = stall;
      repeat (25) random_cmd();
   endtask

   // hold the result side off while commands keep coming, so the input backs up
   task automatic test_backpressure();
      set_all_regs(18'd65536, 18'd32768, 16'd3604, 16'd4063, EDGE_CONST, 6, 5);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_len = 400;
      hold_start = 1;
      repeat (16) begin
         if ($urandom_range(1))
            send_cmd(FUNC_WRITE, 6'($urandom_range(0, 4)), 6'($urandom_range(0, 5)),
                     18'($urandom), 18'($urandom), 0);
         else
            send_cmd(FUNC_READ, 6'($urandom_range(0, 4)), 6'($urandom_range(0, 5)), 0, 0, 0);
      end
   endtask

   initial begin
      clear_shadow(0);
      clear_shadow(1);
      bank_sh = 0;
      rate_da = 18'd65536;
      rate_db = 18'd32768;
      rate_feed = 16'd3604;
      rate_kill = 16'd4063;
      border_mode = EDGE_CONST;
      cols_reg = 7'd64;
      rows_reg = 7'd64;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_grid();
      test_small_wrap();
      test_long_run();
      test_random_phase(0, 0);
      test_random_phase(80, 0);
      test_random_phase(0, 80);
      test_random_phase(27, 27);
      test_backpressure();
      wait_idle();

      $display("Covered %0d commands, %0d result words, %0d generations run,",
               cmds_sent, words_seen, gens_run);
      $display("across all border modes, grid sizes and idle/stall phases; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && pending_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/grs_pkg.sv
rtl/grs_grid_mem.sv
rtl/grs_tap_cell.sv
rtl/grs_update.sv
rtl/gray_scott_reaction_diffusion.sv
sim/tb_top.sv
